// ----- hw/rtl/htld_pkg.sv -----
// ----------------------------------------------------------------------------
// htld_pkg
// Shared sizes, codes and types for the Huffman tree load and walk decoder.
// ----------------------------------------------------------------------------
package htld_pkg;

    localparam int MAX_NODES   = 512;
    localparam int STACK_DEPTH = 256;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int SIDX_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W   = 8;

    typedef enum logic [1:0] {
        ACT_TOKEN = 2'd0,
        ACT_BIT   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_SYMBOL      = 2'd0,
        ST_NOT_READY   = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_EXTRA_TOKEN = 2'd3
    } status_t;

    // One child link as seen from its parent: index plus the child's leaf info,
    // so a step of the walk needs a single table read.
    typedef struct packed {
        logic              leaf;
        logic [SYM_W-1:0]  sym;
        logic [NODE_W-1:0] ptr;
    } node_ref_t;

endpackage

// ----- hw/rtl/huffman_tree_load_and_decode.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// Pre-order Huffman tree loader and one-bit-per-word tree walk decoder.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per accepted edge. action picks
// a tree token (bit_value 1 = leaf carrying leaf_symbol, 0 = internal node), a
// code bit (bit_value 1 = right, 0 = left) or a clear of the tree. Action code
// three is ignored.
// Output channel (out_valid / out_stall): zero or one word per input word:
// symbol and status (0 symbol, 1 tree not ready or single leaf, 2 node or stack
// overflow, 3 token after a complete tree).
// A result is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while in_stall is low. The child links of the current walk node sit
// in registers read from the node tables every cycle, so each code bit costs
// one table read; the loader keeps the top two stack entries in registers.
// A stalled result holds in the output register; a new input word is still
// taken in the cycle the held result leaves, and in_stall is high only while a
// result waits and out_stall is high.
// Reset clears the tree, the stack and the walk; the node tables need no
// clearing pass. Output is empty after reset.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode
    import htld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic             bit_value,
    input  logic [SYM_W-1:0] leaf_symbol,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SYM_W-1:0] symbol,
    output logic [1:0]       status
);

    // node tables and parent stack
    node_ref_t         left_mem  [MAX_NODES];
    node_ref_t         right_mem [MAX_NODES];
    logic [NODE_W-1:0] stack_mem [STACK_DEPTH];

    node_ref_t         left_rd_reg;
    node_ref_t         right_rd_reg;
    logic [NODE_W-1:0] below_reg;

    // control state
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               complete_reg, complete_next;
    logic               last_leaf_reg, last_leaf_next;
    logic               root_leaf_reg, root_leaf_next;
    logic [NODE_W-1:0]  walk_reg, walk_next;
    logic [NODE_W-1:0]  top_reg, top_next;

    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   symbol_reg, symbol_next;
    status_t            status_reg, status_next;

    logic               accept;
    logic               has_result;
    action_t            act;

    logic               pop;
    logic [DEPTH_W-1:0] depth_after;
    node_ref_t          rec;
    node_ref_t          new_ref;

    logic               left_we;
    logic [NODE_W-1:0]  left_waddr;
    logic               right_we;
    logic [NODE_W-1:0]  right_waddr;
    logic               stack_we;
    logic [SIDX_W-1:0]  stack_waddr;
    logic [SIDX_W-1:0]  stack_raddr;
    logic [DEPTH_W-1:0] below_pos;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign act      = action_t'(action);

    assign pop         = (count_reg != '0) && last_leaf_reg && (depth_reg != '0);
    assign depth_after = depth_reg - DEPTH_W'(pop);
    assign rec         = bit_value ? right_rd_reg : left_rd_reg;

    always_comb
    begin
        new_ref.leaf = bit_value;
        new_ref.sym  = leaf_symbol;
        new_ref.ptr  = count_reg[NODE_W-1:0];
    end

    always_comb
    begin
        depth_next     = depth_reg;
        count_next     = count_reg;
        complete_next  = complete_reg;
        last_leaf_next = last_leaf_reg;
        root_leaf_next = root_leaf_reg;
        walk_next      = walk_reg;
        top_next       = top_reg;
        has_result     = 1'b0;
        symbol_next    = '0;
        status_next    = ST_SYMBOL;
        left_we        = 1'b0;
        left_waddr     = count_reg[NODE_W-1:0] - NODE_W'(1);
        right_we       = 1'b0;
        right_waddr    = top_reg;
        stack_we       = 1'b0;
        stack_waddr    = depth_reg[SIDX_W-1:0] - SIDX_W'(1);

        if (accept)
        begin
            unique case (act)
                ACT_TOKEN:
                begin
                    priority if (complete_reg)
                    begin
                        has_result  = 1'b1;
                        status_next = ST_EXTRA_TOKEN;
                    end
                    else if (count_reg >= CNT_W'(MAX_NODES))
                    begin
                        has_result  = 1'b1;
                        status_next = ST_OVERFLOW;
                    end
                    else if (!bit_value && depth_after >= DEPTH_W'(STACK_DEPTH))
                    begin
                        has_result  = 1'b1;
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        // attach: left child of an internal predecessor,
                        // else right child of the parent on top of the stack
                        left_we  = (count_reg != '0) && !last_leaf_reg;
                        right_we = pop;
                        if (count_reg == '0)
                        begin
                            root_leaf_next = bit_value;
                        end
                        last_leaf_next = bit_value;
                        count_next     = count_reg + CNT_W'(1);
                        if (bit_value)
                        begin
                            depth_next    = depth_after;
                            complete_next = (depth_after == '0);
                            if (pop)
                            begin
                                top_next = below_reg;
                            end
                        end
                        else
                        begin
                            top_next = count_reg[NODE_W-1:0];
                            if (!pop)
                            begin
                                // push: spill the old top below
                                stack_we   = (depth_reg != '0);
                                depth_next = depth_reg + DEPTH_W'(1);
                            end
                        end
                    end
                end
                ACT_BIT:
                begin
                    if (!complete_reg || root_leaf_reg)
                    begin
                        has_result  = 1'b1;
                        status_next = ST_NOT_READY;
                    end
                    else if (rec.leaf)
                    begin
                        has_result  = 1'b1;
                        symbol_next = rec.sym;
                        status_next = ST_SYMBOL;
                        walk_next   = '0;
                    end
                    else
                    begin
                        walk_next = rec.ptr;
                    end
                end
                ACT_CLEAR:
                begin
                    depth_next     = '0;
                    count_next     = '0;
                    complete_next  = 1'b0;
                    last_leaf_next = 1'b0;
                    walk_next      = '0;
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end

        if (accept)
        begin
            out_valid_next = has_result;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // keep the entry just below the top of stack prefetched
    assign below_pos   = depth_next - DEPTH_W'(2);
    assign stack_raddr = below_pos[SIDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            count_reg     <= '0;
            complete_reg  <= 1'b0;
            last_leaf_reg <= 1'b0;
            root_leaf_reg <= 1'b0;
            walk_reg      <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            count_reg     <= count_next;
            complete_reg  <= complete_next;
            last_leaf_reg <= last_leaf_next;
            root_leaf_reg <= root_leaf_next;
            walk_reg      <= walk_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_result)
        begin
            symbol_reg <= symbol_next;
            status_reg <= status_next;
        end
    end

    // node tables: one write and one read per table, write data forwarded
    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[left_waddr] <= new_ref;
        end
        if (right_we)
        begin
            right_mem[right_waddr] <= new_ref;
        end
        if (left_we && left_waddr == walk_next)
        begin
            left_rd_reg <= new_ref;
        end
        else
        begin
            left_rd_reg <= left_mem[walk_next];
        end
        if (right_we && right_waddr == walk_next)
        begin
            right_rd_reg <= new_ref;
        end
        else
        begin
            right_rd_reg <= right_mem[walk_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= top_reg;
        end
        if (stack_we && stack_waddr == stack_raddr)
        begin
            below_reg <= top_reg;
        end
        else
        begin
            below_reg <= stack_mem[stack_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign status    = status_reg;

endmodule

// ----- hw/rtl/htld_checker.sv -----
// ----------------------------------------------------------------------------
// htld_checker
// Port-level checks for the Huffman tree load and walk decoder.
// ----------------------------------------------------------------------------
module htld_checker
    import htld_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [1:0]       action,
    input logic             out_valid,
    input logic             out_stall,
    input logic [SYM_W-1:0] symbol,
    input logic [1:0]       status
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // a held word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(status))
        else $error("result word changed while stalled");

    // input is only held off by a waiting result
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with output empty");

    a_err_zero_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_SYMBOL |-> symbol == '0)
        else $error("error word carries a symbol");

    a_silent_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (action == ACT_CLEAR || action == ACT_NONE) |=> !out_valid)
        else $error("clear or unused action produced a result");

    a_bit_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && action == ACT_CLEAR ##1 in_acc && action == ACT_BIT
        |=> out_valid && status == ST_NOT_READY)
        else $error("code bit after clear not rejected");

endmodule

bind huffman_tree_load_and_decode htld_checker u_htld_checker (.*);
